### src/iban_pkg.sv
// shared types, constants and the mod-97 fold function of the account-number checker
package iban_pkg;

	// longest string that is counted, and counter width
	localparam int MAX_LEN    = 34;
	localparam int CNT_W      = 6;
	localparam int PREFIX_LEN = 4;
	localparam int REM_W      = 7;
	localparam int VAL_W      = 6;
	localparam int MOD_BASE   = 97;

	// verdict codes
	localparam logic [1:0] VERDICT_OK  = 2'd0;
	localparam logic [1:0] VERDICT_SUM = 2'd1;
	localparam logic [1:0] VERDICT_FMT = 2'd2;

	// (10 * r) mod 97 for r in 0..96
	localparam logic [REM_W-1:0] MUL10_MOD [0:MOD_BASE-1] = '{
		7'd0,  7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90,
		7'd3,  7'd13, 7'd23, 7'd33, 7'd43, 7'd53, 7'd63, 7'd73, 7'd83, 7'd93,
		7'd6,  7'd16, 7'd26, 7'd36, 7'd46, 7'd56, 7'd66, 7'd76, 7'd86, 7'd96,
		7'd9,  7'd19, 7'd29, 7'd39, 7'd49, 7'd59, 7'd69, 7'd79, 7'd89, 7'd2,
		7'd12, 7'd22, 7'd32, 7'd42, 7'd52, 7'd62, 7'd72, 7'd82, 7'd92, 7'd5,
		7'd15, 7'd25, 7'd35, 7'd45, 7'd55, 7'd65, 7'd75, 7'd85, 7'd95, 7'd8,
		7'd18, 7'd28, 7'd38, 7'd48, 7'd58, 7'd68, 7'd78, 7'd88, 7'd1,  7'd11,
		7'd21, 7'd31, 7'd41, 7'd51, 7'd61, 7'd71, 7'd81, 7'd91, 7'd4,  7'd14,
		7'd24, 7'd34, 7'd44, 7'd54, 7'd64, 7'd74, 7'd84, 7'd94, 7'd7,  7'd17,
		7'd27, 7'd37, 7'd47, 7'd57, 7'd67, 7'd77, 7'd87
	};

	// one classified character between front and back
	typedef struct packed {
		logic             last;
		logic             is_space;
		logic             is_digit;
		logic             is_letter;
		logic [VAL_W-1:0] val;
	} cls_t;

	// one finished string handed to the finishing pipeline
	typedef struct packed {
		logic [PREFIX_LEN-1:0][VAL_W-1:0] held;
		logic [REM_W-1:0]                 rem;
		logic                             bad;
	} fin_t;

	// fold one value 0..35 into a remainder: digits shift by 10, letters by 100
	function automatic logic [REM_W-1:0] fold(input logic [REM_W-1:0] r,
			input logic [VAL_W-1:0] v);
		logic [REM_W-1:0] t;
		logic [8:0]       m;
		logic [7:0]       s;
		// 100 mod 97 is 3
		m = {2'b00, r} * 9'd3;
		if (v < VAL_W'(10)) begin
			t = MUL10_MOD[r];
		end else if (m >= 9'd194) begin
			t = REM_W'(m - 9'd194);
		end else if (m >= 9'd97) begin
			t = REM_W'(m - 9'd97);
		end else begin
			t = m[REM_W-1:0];
		end
		s = {1'b0, t} + {2'b00, v};
		if (s >= 8'd97) begin
			s = s - 8'd97;
		end
		return s[REM_W-1:0];
	endfunction

endpackage

### src/iban_char_if.sv
// character channel: one ascii character per beat with end-of-string flag
interface iban_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### src/iban_res_if.sv
// result channel: one verdict and remainder per beat
interface iban_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [6:0] remainder;

	modport source (output valid, output verdict, output remainder, input ready);
	modport sink   (input valid, input verdict, input remainder, output ready);
endinterface

### src/iban_front.sv
// front end: accepts characters, folds case and classifies them
module iban_front
	import iban_pkg::*;
(
	iban_char_if.sink chars,
	input  logic      q_ready,
	output logic      q_valid,
	output cls_t      q_item
);

	logic [7:0] cu;

	// case folding
	always_comb begin
		cu = chars.char_code;
		if (chars.char_code >= 8'h61 && chars.char_code <= 8'h7A) begin
			cu = chars.char_code - 8'd32;
		end
	end

	// classification and value
	always_comb begin
		q_item           = '0;
		q_item.last      = chars.last_char;
		q_item.is_space  = (chars.char_code == 8'h20);
		if (cu >= 8'h30 && cu <= 8'h39) begin
			q_item.is_digit = 1'b1;
			q_item.val      = VAL_W'(cu - 8'h30);
		end else if (cu >= 8'h41 && cu <= 8'h5A) begin
			q_item.is_letter = 1'b1;
			q_item.val       = VAL_W'(cu - 8'd55);
		end
	end

	assign q_valid     = chars.valid;
	assign chars.ready = q_ready;

endmodule

### src/iban_queue.sv
// two-entry queue between front and back
module iban_queue
	import iban_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cls_t push_item,
	output logic pop_valid,
	input  logic pop_ready,
	output cls_t pop_item
);

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### src/iban_back.sv
// back end: position checks, prefix hold and running mod-97 remainder
module iban_back
	import iban_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  cls_t item,
	output logic fin_valid,
	input  logic fin_ready,
	output fin_t fin_data
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

	logic [REM_W-1:0]                 rem_q, rem_n;
	logic [PREFIX_LEN-1:0][VAL_W-1:0] held_q, held_n;
	logic [CNT_W-1:0]                 cnt_q, cnt_n;
	logic                             err_q, err_n;
	logic                             pop;

	assign item_ready = !item.last || fin_ready;
	assign pop        = item_valid && item_ready;
	assign fin_valid  = item_valid && item.last;

	// next state for this character
	always_comb begin
		rem_n  = rem_q;
		held_n = held_q;
		cnt_n  = cnt_q;
		err_n  = err_q;
		if (!item.is_space) begin
			if (!item.is_digit && !item.is_letter) begin
				err_n = 1'b1;
			end
			if (cnt_q >= MAX_CNT) begin
				err_n = 1'b1;
			end else begin
				if (cnt_q < CNT_W'(PREFIX_LEN)) begin
					if (cnt_q < CNT_W'(2) && !item.is_letter) begin
						err_n = 1'b1;
					end
					if (cnt_q >= CNT_W'(2) && !item.is_digit) begin
						err_n = 1'b1;
					end
					held_n[cnt_q[1:0]] = item.val;
				end else if (item.is_digit || item.is_letter) begin
					rem_n = fold(rem_q, item.val);
				end
				cnt_n = cnt_q + CNT_W'(1);
			end
		end
	end

	// handoff of a finished string
	always_comb begin
		fin_data.held = held_n;
		fin_data.rem  = rem_n;
		fin_data.bad  = err_n || (cnt_n < CNT_W'(PREFIX_LEN + 1));
	end

	// prefix values
	always_ff @(posedge clk) begin
		if (pop) begin
			held_q <= held_n;
		end
	end

	// running state, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (pop) begin
			if (item.last) begin
				rem_q <= '0;
				cnt_q <= '0;
				err_q <= 1'b0;
			end else begin
				rem_q <= rem_n;
				cnt_q <= cnt_n;
				err_q <= err_n;
			end
		end
	end

endmodule

### src/iban_fin.sv
// finishing pipeline: folds the four held characters and forms the verdict
module iban_fin
	import iban_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fin_valid,
	output logic     fin_ready,
	input  fin_t     fin_data,
	iban_res_if.source results
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	fin_t d_s1, d_s2, d_s3, d_s4;
	logic [REM_W-1:0] rem_last;
	logic [1:0]       verdict_s5;
	logic [REM_W-1:0] rem_s5;

	// stage enables, back to front
	assign en_s5     = !v_s5 || results.ready;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign fin_ready = en_s1;

	assign rem_last = fold(d_s4.rem, d_s4.held[3]);

	// stage data: stage 1 captures, each later stage folds in one prefix character
	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1 <= fin_data;
		end
		if (en_s2) begin
			d_s2.held <= d_s1.held;
			d_s2.rem  <= fold(d_s1.rem, d_s1.held[0]);
			d_s2.bad  <= d_s1.bad;
		end
		if (en_s3) begin
			d_s3.held <= d_s2.held;
			d_s3.rem  <= fold(d_s2.rem, d_s2.held[1]);
			d_s3.bad  <= d_s2.bad;
		end
		if (en_s4) begin
			d_s4.held <= d_s3.held;
			d_s4.rem  <= fold(d_s3.rem, d_s3.held[2]);
			d_s4.bad  <= d_s3.bad;
		end
		if (en_s5) begin
			if (d_s4.bad) begin
				verdict_s5 <= VERDICT_FMT;
				rem_s5     <= '0;
			end else begin
				verdict_s5 <= (rem_last == REM_W'(1)) ? VERDICT_OK : VERDICT_SUM;
				rem_s5     <= rem_last;
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= fin_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	assign results.valid     = v_s5;
	assign results.verdict   = verdict_s5;
	assign results.remainder = rem_s5;

endmodule

### src/iban_mod97_checker.sv
// top level of the account-number mod-97 checker
// Takes one character a beat on chars and sustains one character per cycle, spaces included;
// a character costs one table lookup (digit) or a times-3 reduce (letter), plus one
// add-and-reduce on the running remainder, done combinationally in the back end. The front
// end classifies each character straight into a two-entry queue, so a stall on results only
// backs up once the queue and the five-stage finishing pipeline are full. A verdict beat
// appears on results after the last character of its string has gone through the queue, the
// capture stage and the stages that fold in the first three held characters, and reaches the
// output stage, which folds in the fourth and forms the verdict.
// Verdict 0 means acceptable, 1 a checksum mismatch, 2 a format fault (remainder then 0).
module iban_mod97_checker
	import iban_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	iban_char_if.sink  chars,
	iban_res_if.source results
);

	logic q_push_valid, q_push_ready;
	cls_t q_push_item;
	logic q_pop_valid, q_pop_ready;
	cls_t q_pop_item;
	logic fin_valid, fin_ready;
	fin_t fin_data;

	// classification
	iban_front u_front (
		.chars   (chars),
		.q_ready (q_push_ready),
		.q_valid (q_push_valid),
		.q_item  (q_push_item)
	);

	// decoupling queue
	iban_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_item  (q_push_item),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_item   (q_pop_item)
	);

	// per-character state update
	iban_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_pop_valid),
		.item_ready (q_pop_ready),
		.item       (q_pop_item),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.fin_data   (fin_data)
	);

	// prefix fold and verdict
	iban_fin u_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin_data  (fin_data),
		.results   (results)
	);

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// testbench for the account-number mod-97 checker: a table of short strings, then random ones
module tb;
	import iban_pkg::*;

	typedef struct packed {
		logic [1:0]       verdict;
		logic [REM_W-1:0] remainder;
	} verdict_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       typed;
		verdict_t   res;
	} char_row_t;

	localparam int         N_ROWS     = 24;
	localparam int         N_RANDOM   = 1850;
	localparam int         IDLE_PCT   = 26;
	localparam int         DRAIN_CYC  = 20;
	localparam int         TIMEOUT_NS = 5_000_000;
	localparam logic [7:0] SPACE      = 8'h20;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   n_fail;
	int   chars_sent;

	iban_char_if chars ();
	iban_res_if  results ();

	// verdicts still owed by the block, oldest first
	verdict_t expected_verdicts [$];

	// predictor copy of the string state
	logic [REM_W-1:0] run_rem;
	logic [VAL_W-1:0] held_vals [PREFIX_LEN];
	logic [CNT_W-1:0] n_counted;
	logic             fmt_bad;

	// directed strings; verdicts typed in only for the format faults
	char_row_t directed_rows [N_ROWS] = '{
		// lower case, inner space, trailing space with the last flag: checksum good
		'{"a", 1'b0, 1'b0, '0},
		'{"b", 1'b0, 1'b0, '0},
		'{SPACE, 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"z", 1'b0, 1'b0, '0},
		'{SPACE, 1'b1, 1'b0, '0},
		// checksum off by one
		'{"A", 1'b0, 1'b0, '0},
		'{"B", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{"Z", 1'b1, 1'b0, '0},
		// letter where a check digit belongs
		'{"A", 1'b0, 1'b0, '0},
		'{"B", 1'b0, 1'b0, '0},
		'{"C", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"0", 1'b1, 1'b1, '{VERDICT_FMT, 7'd0}},
		// extreme codes are neither letters nor digits
		'{"A", 1'b0, 1'b0, '0},
		'{"B", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, '{VERDICT_FMT, 7'd0}},
		// lone space: nothing counted, too short
		'{SPACE, 1'b1, 1'b1, '{VERDICT_FMT, 7'd0}}
	};

	iban_mod97_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.results(results)
	);

	// append one value 0..35 to a remainder: one decimal digit or two
	function automatic logic [REM_W-1:0] mod97_fold(input logic [REM_W-1:0] r,
			input logic [VAL_W-1:0] v);
		int unsigned acc;
		acc = (v < 10) ? int'(r) * 10 + int'(v) : int'(r) * 100 + int'(v);
		return REM_W'(acc % MOD_BASE);
	endfunction

	function automatic void clear_string_state();
		run_rem   = '0;
		n_counted = '0;
		fmt_bad   = 1'b0;
		foreach (held_vals[k]) held_vals[k] = '0;
	endfunction

	// advance the string state by one character; returns 1 when a verdict is due
	function automatic logic predict_char(input logic [7:0] code, input logic last,
			output verdict_t res);
		logic [7:0]       c;
		logic             is_digit;
		logic             is_letter;
		logic [VAL_W-1:0] v;
		logic [REM_W-1:0] r;
		c         = code;
		is_digit  = 1'b0;
		is_letter = 1'b0;
		v         = '0;
		res       = '0;
		if (c != SPACE) begin
			// fold case, then classify
			if (c >= "a" && c <= "z") c = c - 8'h20;
			if (c >= "0" && c <= "9") begin
				is_digit = 1'b1;
				v        = VAL_W'(c - "0");
			end else if (c >= "A" && c <= "Z") begin
				is_letter = 1'b1;
				v         = VAL_W'(c - "A" + 10);
			end else begin
				fmt_bad = 1'b1;
			end
			// position bookkeeping, prefix shape and length limit
			if (n_counted >= MAX_LEN) begin
				fmt_bad = 1'b1;
			end else begin
				if (n_counted < PREFIX_LEN) begin
					if (n_counted < 2 && !is_letter) fmt_bad = 1'b1;
					if (n_counted >= 2 && !is_digit) fmt_bad = 1'b1;
					held_vals[n_counted[1:0]] = v;
				end else if (is_digit || is_letter) begin
					run_rem = mod97_fold(run_rem, v);
				end
				n_counted = n_counted + 1'b1;
			end
		end
		if (!last) return 1'b0;
		// rotate the held country code and check digits to the end
		r = run_rem;
		foreach (held_vals[k]) r = mod97_fold(r, held_vals[k]);
		if (fmt_bad || n_counted < 5) begin
			res.verdict   = VERDICT_FMT;
			res.remainder = '0;
		end else begin
			res.verdict   = (r == 1) ? VERDICT_OK : VERDICT_SUM;
			res.remainder = r;
		end
		clear_string_state();
		return 1'b1;
	endfunction

	// drive one character beat, wait for it to be taken, and log its verdict if any
	task automatic send_char(input logic [7:0] code, input logic last, input logic typed,
			input verdict_t typed_res);
		verdict_t res;
		while ($urandom_range(99) < idle_pct) begin
			chars.valid <= 1'b0;
			@(negedge clk);
		end
		chars.valid     <= 1'b1;
		chars.char_code <= code;
		chars.last_char <= last;
		do @(posedge clk); while (!chars.ready);
		if (predict_char(code, last, res)) expected_verdicts.push_back(typed ? typed_res : res);
		chars_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_alnum(input logic letter);
		logic [7:0] c;
		if (letter) begin
			c = 8'h41 + 8'($urandom_range(25));
			if ($urandom_range(2) == 0) c = c + 8'h20;
		end else begin
			c = 8'h30 + 8'($urandom_range(9));
		end
		return c;
	endfunction

	function automatic logic [VAL_W-1:0] alnum_value(input logic [7:0] c);
		if (c >= "a") return VAL_W'(c - "a" + 10);
		if (c >= "A") return VAL_W'(c - "A" + 10);
		return VAL_W'(c - "0");
	endfunction

	// one random string: mostly well formed, some too long, some broken, some noise
	task automatic send_random_string();
		logic [7:0]       body [$];
		logic [7:0]       text [$];
		logic [REM_W-1:0] r;
		logic             trail;
		int               kind;
		int               sel;
		int               bban_len;
		int               chk;
		kind = $urandom_range(99);
		if (kind >= 88) begin
			repeat ($urandom_range(8, 1)) text.push_back(8'($urandom));
		end else begin
			sel = $urandom_range(19);
			if (kind >= 60 && kind < 75) bban_len = $urandom_range(MAX_LEN, MAX_LEN - PREFIX_LEN + 1);
			else if (sel == 0) bban_len = MAX_LEN - PREFIX_LEN;
			else if (sel == 1) bban_len = 0;
			else bban_len = $urandom_range(26, 1);
			repeat (bban_len) body.push_back(rand_alnum($urandom_range(1)));
			text.push_back(rand_alnum(1'b1));
			text.push_back(rand_alnum(1'b1));
			// check digits that make the string pass, most of the time
			r = '0;
			foreach (body[i]) r = mod97_fold(r, alnum_value(body[i]));
			r = mod97_fold(r, alnum_value(text[0]));
			r = mod97_fold(r, alnum_value(text[1]));
			r = mod97_fold(r, '0);
			r = mod97_fold(r, '0);
			chk = ($urandom_range(9) < 7) ? 98 - int'(r) : $urandom_range(99);
			text.push_back(8'(8'h30 + chk / 10));
			text.push_back(8'(8'h30 + chk % 10));
			foreach (body[i]) text.push_back(body[i]);
			// broken string: one character replaced by any code
			if (kind >= 75) text[$urandom_range(text.size() - 1)] = 8'($urandom);
		end
		trail = ($urandom_range(19) == 0);
		foreach (text[i]) begin
			if ($urandom_range(9) == 0) send_char(SPACE, 1'b0, 1'b0, '0);
			send_char(text[i], (i == text.size() - 1) && !trail, 1'b0, '0);
		end
		if (trail) send_char(SPACE, 1'b1, 1'b0, '0);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side backpressure
	always @(negedge clk) begin
		results.ready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// compare each result beat with the oldest expected verdict
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && results.valid && results.ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result beat: verdict %0d remainder %0d",
					results.verdict, results.remainder);
				n_fail++;
			end else begin
				want = expected_verdicts.pop_front();
				if (results.verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, results.verdict);
					n_fail++;
				end
				if (results.remainder !== want.remainder) begin
					$error("remainder: expected %0d, got %0d", want.remainder,
						results.remainder);
					n_fail++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("tb: FAIL");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int n_strings;
		chars.valid     = 1'b0;
		chars.char_code = '0;
		chars.last_char = 1'b0;
		results.ready   = 1'b0;
		idle_pct        = IDLE_PCT;
		n_fail          = 0;
		chars_sent      = 0;
		n_strings       = 0;
		clear_string_state();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			send_char(directed_rows[i].code, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].res);
		end

		// random strings, with one stretch where neither side idles
		chars_sent = 0;
		while (chars_sent < N_RANDOM) begin
			idle_pct = (n_strings >= 20 && n_strings < 45) ? 0 : IDLE_PCT;
			send_random_string();
			n_strings++;
		end
		chars.valid <= 1'b0;
		idle_pct = IDLE_PCT;

		// drain
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (n_fail == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
